// ===== rtl/ate_pkg.sv =====
// ----------------------------------------------------------------------------
// ate_pkg
// Shared types and constants of the address table engine: request and
// result records, request and status codes, sequencer states.
// ----------------------------------------------------------------------------
package ate_pkg;

  // default number of table slots
  localparam int unsigned TableDepth = 16;

  // widths of the stored halves of one slot
  localparam int unsigned KeyW   = 39;  // interface index and kind
  localparam int unsigned AddrW  = 38;  // ipv4 address and prefix length
  localparam int unsigned EntryW = KeyW + AddrW;

  // request codes
  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_DELETE  = 2'd1,
    REQ_DEL_ALL = 2'd2,
    REQ_FIND    = 2'd3
  } req_type_e;

  // result status codes
  typedef enum logic [2:0] {
    STS_DONE      = 3'd0,
    STS_PRESENT   = 3'd1,
    STS_FULL      = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_FOUND     = 3'd4
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // one request
  typedef struct packed {
    req_type_e   req_type;
    logic [30:0] ifi;
    logic [7:0]  addr_kind;
    logic [31:0] ip_addr;
    logic [5:0]  prefix_len;
    logic [4:0]  start_index;
  } req_t;

  // one result
  typedef struct packed {
    status_e     status;
    logic [3:0]  slot_index;
    logic [31:0] found_ip;
    logic [5:0]  found_prefix;
    logic [4:0]  used_entries;
    logic [4:0]  removed_count;
  } rsp_t;

endpackage

// ===== rtl/ate_store.sv =====
// ----------------------------------------------------------------------------
// ate_store
// Slot memory with one write and one registered read port, plus one
// occupancy flag per slot. A slot whose flag is clear reads as all zero.
// ----------------------------------------------------------------------------
module ate_store import ate_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepth,
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // read port, data registered
  input  logic              rd_en_i,
  input  logic [IdxW-1:0]   rd_idx_i,
  output logic [EntryW-1:0] rd_entry_o,
  output logic              rd_occ_o,
  // write port, sets the flag when the entry is not all zero
  input  logic              wr_en_i,
  input  logic [IdxW-1:0]   wr_idx_i,
  input  logic [EntryW-1:0] wr_entry_i,
  // slot clear
  input  logic              clr_en_i,
  input  logic [IdxW-1:0]   clr_idx_i
);

  logic [EntryW-1:0]      mem_q [TABLE_DEPTH];
  logic [EntryW-1:0]      rdata_q;
  logic                   rd_occ_q;
  logic [TABLE_DEPTH-1:0] occ_q;
  logic [TABLE_DEPTH-1:0] occ_d;

  // memory write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_entry_i;
    end
  end

  // memory read, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_idx_i];
    end
  end

  // occupancy flags
  always_comb begin
    occ_d = occ_q;
    if (wr_en_i) begin
      occ_d[wr_idx_i] = (wr_entry_i != '0);
    end
    if (clr_en_i) begin
      occ_d[clr_idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      rd_occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (rd_en_i) begin
        rd_occ_q <= occ_q[rd_idx_i];
      end
    end
  end

  // empty slots read as zero
  assign rd_occ_o   = rd_occ_q;
  assign rd_entry_o = rd_occ_q ? rdata_q : '0;

endmodule

// ===== rtl/address_table_engine.sv =====
// ----------------------------------------------------------------------------
// address_table_engine
// Slot table of interface addresses with a high-water count: add, delete,
// delete-all-matching and find-next requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_i is taken at a rising edge with start high and busy
//   low. busy stays high until the cycle that carries the result. The result
//   sits on rsp_o for one cycle, marked by done_o; the receiver must take it
//   then. Every request gives exactly one result.
// Timing:
//   Each request reads the slots below the high-water count through the
//   single memory read port, one slot per cycle, pipelined against the
//   compare. Add, delete and delete-all scan all used slots; find-next stops
//   at its first hit. The next request can start in the cycle that carries
//   the result. The high-water count is trimmed during the same scan, with
//   no extra pass.
// Reset:
//   Occupancy flags and the count clear at once, so every slot reads empty;
//   a request may start in the first cycle after reset.
// ----------------------------------------------------------------------------
module address_table_engine import ate_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CmpW = (CntW > 5) ? CntW : 5;

  state_e state_q, state_d;

  req_t             req_q, req_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic             hit_vld_q, hit_vld_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  logic             fe_vld_q, fe_vld_d;
  logic [IdxW-1:0]  fe_idx_q, fe_idx_d;
  logic [CntW-1:0]  keep_hi_q, keep_hi_d;
  logic [CntW-1:0]  pend_q, pend_d;
  logic [CntW-1:0]  comm_q, comm_d;
  logic [AddrW-1:0] fnd_addr_q, fnd_addr_d;
  rsp_t             rsp_q, rsp_d;
  logic             done_q, done_d;

  logic              accept;
  logic              rd_en;
  logic [EntryW-1:0] rd_entry;
  logic              rd_occ;
  logic              wr_en;
  logic [IdxW-1:0]   wr_idx;
  logic              clr_en;
  logic [KeyW-1:0]   req_key;
  logic [AddrW-1:0]  req_addr;
  logic              key_match;
  logic              exact;
  logic              find_hit;
  logic              scan_end;
  logic [CntW-1:0]  removed;

  assign accept   = start && (state_q == ST_IDLE);
  assign req_key  = {req_q.ifi, req_q.addr_kind};
  assign req_addr = {req_q.ip_addr, req_q.prefix_len};

  // compare of the slot read in the previous cycle
  assign key_match = (rd_entry[EntryW-1:AddrW] == req_key);
  assign exact     = key_match && (rd_entry[AddrW-1:0] == req_addr);
  assign find_hit  = (state_q == ST_SCAN) && cmp_vld_q && key_match &&
                     (req_q.req_type == REQ_FIND);

  // read issue: one slot a cycle below the count
  assign rd_en    = (state_q == ST_SCAN) && (rd_idx_q < cnt_q);
  assign scan_end = !rd_en && !cmp_vld_q;

  // delete-all tally: matches up to the last kept or cleared entry, or the
  // single leading match on an empty slot past it
  assign removed = (comm_q != '0) ? comm_q :
                   ((pend_q != '0) ? CntW'(1) : '0);

  ate_store #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_idx_i   (IdxW'(rd_idx_q)),
    .rd_entry_o (rd_entry),
    .rd_occ_o   (rd_occ),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_idx),
    .wr_entry_i ({req_key, req_addr}),
    .clr_en_i   (clr_en),
    .clr_idx_i  (cmp_idx_q)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (find_hit || scan_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    busy   = (state_q != ST_IDLE);
    done_o = done_q;
    rsp_o  = rsp_q;
  end

  // datapath: scan bookkeeping, table updates and result
  always_comb begin
    req_d      = req_q;
    cnt_d      = cnt_q;
    rd_idx_d   = rd_idx_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    hit_vld_d  = hit_vld_q;
    hit_idx_d  = hit_idx_q;
    fe_vld_d   = fe_vld_q;
    fe_idx_d   = fe_idx_q;
    keep_hi_d  = keep_hi_q;
    pend_d     = pend_q;
    comm_d     = comm_q;
    fnd_addr_d = fnd_addr_q;
    rsp_d      = rsp_q;
    done_d     = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = fe_idx_q;
    clr_en     = 1'b0;

    // request transfer: set up the scan
    if (accept) begin
      req_d     = req_i;
      hit_vld_d = 1'b0;
      fe_vld_d  = 1'b0;
      keep_hi_d = '0;
      pend_d    = '0;
      comm_d    = '0;
      if (req_i.req_type == REQ_FIND) begin
        if (CmpW'(req_i.start_index) >= CmpW'(cnt_q)) begin
          rd_idx_d = cnt_q;
        end else begin
          rd_idx_d = CntW'(req_i.start_index);
        end
      end else begin
        rd_idx_d = '0;
      end
    end

    // scan: advance read pointer
    if (rd_en) begin
      rd_idx_d  = rd_idx_q + CntW'(1);
      cmp_vld_d = 1'b1;
      cmp_idx_d = IdxW'(rd_idx_q);
    end

    // scan: evaluate the slot just read
    if ((state_q == ST_SCAN) && cmp_vld_q) begin
      case (req_q.req_type)
        REQ_ADD: begin
          if (exact && !hit_vld_q) begin
            hit_vld_d = 1'b1;
            hit_idx_d = cmp_idx_q;
          end
          if (!rd_occ && !fe_vld_q) begin
            fe_vld_d = 1'b1;
            fe_idx_d = cmp_idx_q;
          end
        end
        REQ_DELETE: begin
          if (exact && !hit_vld_q) begin
            hit_vld_d = 1'b1;
            hit_idx_d = cmp_idx_q;
            clr_en    = 1'b1;
          end else if (rd_occ) begin
            keep_hi_d = CntW'(cmp_idx_q) + CntW'(1);
          end
        end
        REQ_DEL_ALL: begin
          if (rd_occ) begin
            comm_d = comm_q + pend_q + CntW'(key_match);
            pend_d = '0;
            if (!key_match) begin
              keep_hi_d = CntW'(cmp_idx_q) + CntW'(1);
            end
          end else begin
            pend_d = pend_q + CntW'(key_match);
          end
          clr_en = key_match;
        end
        REQ_FIND: begin
          if (key_match) begin
            hit_vld_d  = 1'b1;
            hit_idx_d  = cmp_idx_q;
            fnd_addr_d = rd_entry[AddrW-1:0];
          end
        end
        default: ;
      endcase
    end

    // finish: write back, trim and build the result
    if (state_q == ST_FINISH) begin
      done_d = 1'b1;
      rsp_d  = '0;
      rsp_d.status = STS_NOT_FOUND;
      case (req_q.req_type)
        REQ_ADD: begin
          if (hit_vld_q) begin
            rsp_d.status     = STS_PRESENT;
            rsp_d.slot_index = 4'(hit_idx_q);
          end else if (fe_vld_q) begin
            wr_en            = 1'b1;
            wr_idx           = fe_idx_q;
            rsp_d.status     = STS_DONE;
            rsp_d.slot_index = 4'(fe_idx_q);
          end else if (cnt_q < CntW'(TABLE_DEPTH)) begin
            wr_en            = 1'b1;
            wr_idx           = IdxW'(cnt_q);
            cnt_d            = cnt_q + CntW'(1);
            rsp_d.status     = STS_DONE;
            rsp_d.slot_index = 4'(cnt_q);
          end else begin
            rsp_d.status = STS_FULL;
          end
        end
        REQ_DELETE: begin
          if (hit_vld_q) begin
            cnt_d               = keep_hi_q;
            rsp_d.status        = STS_DONE;
            rsp_d.slot_index    = 4'(hit_idx_q);
            rsp_d.removed_count = 5'd1;
          end
        end
        REQ_DEL_ALL: begin
          if (removed != '0) begin
            cnt_d        = keep_hi_q;
            rsp_d.status = STS_DONE;
          end
          rsp_d.removed_count = 5'(removed);
        end
        REQ_FIND: begin
          if (hit_vld_q) begin
            rsp_d.status       = STS_FOUND;
            rsp_d.slot_index   = 4'(hit_idx_q);
            rsp_d.found_ip     = fnd_addr_q[AddrW-1:6];
            rsp_d.found_prefix = fnd_addr_q[5:0];
          end
        end
        default: ;
      endcase
      rsp_d.used_entries = 5'(cnt_d);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      done_q    <= done_d;
    end
  end

  // scan and payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_vld_q  <= hit_vld_d;
    hit_idx_q  <= hit_idx_d;
    fe_vld_q   <= fe_vld_d;
    fe_idx_q   <= fe_idx_d;
    keep_hi_q  <= keep_hi_d;
    pend_q     <= pend_d;
    comm_q     <= comm_d;
    fnd_addr_q <= fnd_addr_d;
    rsp_q      <= rsp_d;
  end

endmodule
